FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SWTB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("timer bank assertion failed");

// Expression must never be true at a clock edge outside reset.
`define SWTB_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("timer bank forbidden condition seen");

`endif

FILE: hdl/swtb_pkg.sv
// ----------------------------------------------------------------------------
// swtb_pkg
// Shared constants, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swtb_pkg;

  localparam int unsigned TIMER_COUNT = 8;
  localparam int unsigned IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned REP_W       = $clog2(MAX_RESULTS + 1);

  // request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_SCAN  = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_STOP  = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;

  // result kinds
  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATE  = 1'b1;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_RUNNING = 2'd1,
    PH_TIMEOUT = 2'd2
  } phase_t;

  typedef struct packed {
    logic do_tick;
    logic do_start;
    logic do_stop;
    logic do_query;
    logic scan_start;
    logic scan_busy;
    logic scan_step;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit_rep;
    logic pend_valid;
    logic slot_free;
    logic last_idx;
  } dp_stat_t;

  // low three bits of a timer index, as reported in which_timer
  function automatic logic [2:0] which_of(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[2:0];
  endfunction

endpackage

FILE: hdl/swtb_if.sv
// ----------------------------------------------------------------------------
// Timer bank channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface timer_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  timer_id;
  logic        periodic;
  logic [31:0] delay_ticks;
  logic [15:0] user_tag;

  modport source (output valid, req_type, timer_id, periodic, delay_ticks, user_tag,
                  input ready);
  modport sink (input valid, req_type, timer_id, periodic, delay_ticks, user_tag,
                output ready);
endinterface

interface timer_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  which_timer;
  logic [1:0]  timer_status;
  logic [15:0] expiry_tag;
  logic [31:0] tick_now;
  logic        last_of_run;

  modport source (output valid, result_kind, which_timer, timer_status, expiry_tag,
                  tick_now, last_of_run, input ready);
  modport sink (input valid, result_kind, which_timer, timer_status, expiry_tag,
                tick_now, last_of_run, output ready);
endinterface

FILE: hdl/swtb_ctrl.sv
// ----------------------------------------------------------------------------
// swtb_ctrl
// Request decoder and scan/flush sequencer for the timer bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swtb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  swtb_pkg::dp_stat_t stat,
  output swtb_pkg::ctl_cmd_t cmd
);
  import swtb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready      = (state_r == ST_IDLE);
    accept        = in_valid && in_ready;
    cmd.scan_busy = (state_r == ST_SCAN);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_TICK:  cmd.do_tick = 1'b1;
            REQ_SCAN: begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            REQ_START: cmd.do_start = 1'b1;
            REQ_STOP:  cmd.do_stop = 1'b1;
            REQ_QUERY: begin
              cmd.do_query = 1'b1;
              state_nxt    = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // hold the scan while an older event cannot leave the pending slot
        cmd.scan_step = !(stat.hit_rep && stat.pend_valid && !stat.slot_free);
        if (cmd.scan_step && stat.last_idx) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SWTB_ASSERT(a_flush_has_word, clk, rst_n, cmd.flush |-> (stat.pend_valid && stat.slot_free))
  `SWTB_ASSERT(a_scan_ends_in_flush, clk, rst_n,
               (cmd.scan_step && stat.last_idx) |=> (state_r == ST_FLUSH))

endmodule

FILE: hdl/swtb_dp.sv
// ----------------------------------------------------------------------------
// swtb_dp
// Timer state, tick counter, pending result slot and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swtb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_timer_id,
  input  logic               in_periodic,
  input  logic [31:0]        in_delay_ticks,
  input  logic [15:0]        in_user_tag,
  input  swtb_pkg::ctl_cmd_t cmd,
  output swtb_pkg::dp_stat_t stat,
  timer_rsp_if.source        out_rsp
);
  import swtb_pkg::*;

  logic [31:0]      tick_cnt_r;
  phase_t           phase_r    [TIMER_COUNT];
  logic             mode_r     [TIMER_COUNT];
  logic [31:0]      deadline_r [TIMER_COUNT];
  logic [31:0]      period_r   [TIMER_COUNT];
  logic [15:0]      tag_r      [TIMER_COUNT];
  logic [IDX_W-1:0] scan_idx_r;
  logic [REP_W-1:0] rep_cnt_r;

  logic             pend_valid_r;
  logic             pend_kind_r;
  logic [2:0]       pend_which_r;
  logic [1:0]       pend_status_r;
  logic [15:0]      pend_tag_r;
  logic [31:0]      pend_tick_r;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [2:0]       out_which_r;
  logic [1:0]       out_status_r;
  logic [15:0]      out_tag_r;
  logic [31:0]      out_tick_r;
  logic             out_last_r;

  logic [IDX_W-1:0] id_idx;
  logic             valid_id;
  logic [IDX_W-1:0] rd_idx;
  phase_t           rd_phase;
  logic             rd_mode;
  logic [31:0]      rd_deadline;
  logic [31:0]      rd_period;
  logic [15:0]      rd_tag;
  logic             hit;
  logic             hit_rep;
  logic [31:0]      reload_sum;
  logic [31:0]      start_sum;
  phase_t           query_status;
  logic [15:0]      query_tag;
  logic             push;

  always_comb begin
    id_idx      = IDX_W'(in_timer_id);
    valid_id    = 32'(in_timer_id) < 32'(TIMER_COUNT);
    rd_idx      = cmd.scan_busy ? scan_idx_r : id_idx;
    rd_phase    = phase_r[rd_idx];
    rd_mode     = mode_r[rd_idx];
    rd_deadline = deadline_r[rd_idx];
    rd_period   = period_r[rd_idx];
    rd_tag      = tag_r[rd_idx];

    hit        = (rd_phase == PH_RUNNING) && (rd_deadline <= tick_cnt_r);
    hit_rep    = hit && (rep_cnt_r < REP_W'(MAX_RESULTS));
    reload_sum = tick_cnt_r + rd_period;
    start_sum  = tick_cnt_r + in_delay_ticks;

    query_status = PH_STOPPED;
    query_tag    = '0;
    if (valid_id) begin
      query_tag = rd_tag;
      if (rd_phase == PH_RUNNING || rd_phase == PH_TIMEOUT) begin
        query_status = rd_phase;
      end
    end

    push = (cmd.scan_step && hit_rep && pend_valid_r) || cmd.flush;

    stat.hit_rep    = hit_rep;
    stat.pend_valid = pend_valid_r;
    stat.slot_free  = !out_valid_r || out_rsp.ready;
    stat.last_idx   = (scan_idx_r == IDX_W'(TIMER_COUNT - 1));
  end

  // control and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r   <= '0;
      scan_idx_r   <= '0;
      rep_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        phase_r[i]    <= PH_STOPPED;
        mode_r[i]     <= 1'b0;
        deadline_r[i] <= '0;
        period_r[i]   <= '0;
        tag_r[i]      <= '0;
      end
    end else begin
      if (cmd.do_tick) begin
        tick_cnt_r <= tick_cnt_r + 32'd1;
      end
      if (cmd.do_start && valid_id) begin
        deadline_r[id_idx] <= start_sum;
        period_r[id_idx]   <= in_delay_ticks;
        phase_r[id_idx]    <= PH_RUNNING;
        mode_r[id_idx]     <= in_periodic;
        tag_r[id_idx]      <= in_user_tag;
      end
      if (cmd.do_stop && valid_id) begin
        phase_r[id_idx] <= PH_STOPPED;
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        rep_cnt_r  <= '0;
      end
      if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
        case (rd_phase)
          PH_RUNNING: begin
            if (hit) begin
              phase_r[scan_idx_r] <= PH_TIMEOUT;
            end
          end
          PH_TIMEOUT: begin
            if (!rd_mode) begin
              phase_r[scan_idx_r] <= PH_STOPPED;
            end else begin
              deadline_r[scan_idx_r] <= reload_sum;
              phase_r[scan_idx_r]    <= PH_RUNNING;
            end
          end
          default: ;
        endcase
        if (hit_rep) begin
          rep_cnt_r    <= rep_cnt_r + REP_W'(1);
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.do_query) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
        out_last_r  <= cmd.flush;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending word and output word payload
  always_ff @(posedge clk) begin
    if (cmd.scan_step && hit_rep) begin
      pend_kind_r   <= KIND_EXPIRY;
      pend_which_r  <= which_of(scan_idx_r);
      pend_status_r <= PH_TIMEOUT;
      pend_tag_r    <= rd_tag;
      pend_tick_r   <= tick_cnt_r;
    end else if (cmd.do_query) begin
      pend_kind_r   <= KIND_STATE;
      pend_which_r  <= in_timer_id;
      pend_status_r <= query_status;
      pend_tag_r    <= query_tag;
      pend_tick_r   <= tick_cnt_r;
    end
    if (push) begin
      out_kind_r   <= pend_kind_r;
      out_which_r  <= pend_which_r;
      out_status_r <= pend_status_r;
      out_tag_r    <= pend_tag_r;
      out_tick_r   <= pend_tick_r;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_kind  = out_kind_r;
  assign out_rsp.which_timer  = out_which_r;
  assign out_rsp.timer_status = out_status_r;
  assign out_rsp.expiry_tag   = out_tag_r;
  assign out_rsp.tick_now     = out_tick_r;
  assign out_rsp.last_of_run  = out_last_r;

  `SWTB_NEVER(a_no_overwrite, clk, rst_n, push && out_valid_r && !out_rsp.ready)
  `SWTB_ASSERT(a_flush_marks_last, clk, rst_n, cmd.flush |=> (out_valid_r && out_last_r))
  `SWTB_ASSERT(a_report_cap, clk, rst_n, rep_cnt_r <= REP_W'(MAX_RESULTS))

endmodule

FILE: hdl/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// Tick, start and stop are each taken by a single decode; a query is decoded
// into the pending slot, then moves to the output register. An update pass
// decodes, visits each timer in turn on a single compare/reload unit, then
// releases its final word; a busy output stretches both query and pass.
// Synchronous active-low reset clears all timer state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module software_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  timer_req_if.sink   in_req,
  timer_rsp_if.source out_rsp
);
  import swtb_pkg::*;

  // Commands flow from the sequencer to the datapath; status flows back.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The sequencer decodes one request word at a time. During an update pass
  // it steps the scan index once per cycle and holds whenever a freshly found
  // expiry would have to displace an undelivered pending word.
  swtb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_req_type (in_req.req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  // The datapath keeps the tick counter and the per-timer registers. Each
  // result word waits in a pending slot until the next one (or the end of
  // the pass) is known, so the last word of a run carries its marker, then
  // moves to the output register, which lets new requests in while it waits.
  swtb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_timer_id    (in_req.timer_id),
    .in_periodic    (in_req.periodic),
    .in_delay_ticks (in_req.delay_ticks),
    .in_user_tag    (in_req.user_tag),
    .cmd            (cmd),
    .stat           (stat),
    .out_rsp        (out_rsp)
  );

endmodule

FILE: tb/sv/timer_bank_checker.sv
// ----------------------------------------------------------------------------
// timer_bank_checker
// Watches the request and result channels, keeps a shadow copy of the timer
// bank and checks every result word, field by field, in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_bank_checker
  import swtb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  timer_req_if req_mon,
  timer_rsp_if rsp_mon,
  output int   fail_count,
  output int   words_owed,
  output int   expiries_seen,
  output int   replies_seen
);

  typedef struct packed {
    logic        kind;
    logic [2:0]  which;
    phase_t      status;
    logic [15:0] tag;
    logic [31:0] tick;
    logic        last;
  } timer_word_t;

  // shadow timer bank
  logic [31:0] tick_cnt;
  phase_t      phase_q   [TIMER_COUNT];
  logic        reload_on [TIMER_COUNT];
  logic [31:0] due_at    [TIMER_COUNT];
  logic [31:0] period_q  [TIMER_COUNT];
  logic [15:0] tag_q     [TIMER_COUNT];

  timer_word_t owed_q[$];
  timer_word_t got_w;
  timer_word_t want_w;
  int          mism;
  int          n_exp;
  int          n_rep;

  // Apply one request word to the shadow bank and queue the words it owes.
  task automatic step_bank(input logic [2:0] code, input logic [2:0] id, input logic per,
                           input logic [31:0] dly, input logic [15:0] tg);
    timer_word_t batch [MAX_RESULTS];
    int          n;
    bit          id_ok;
    n = 0;
    id_ok = (32'(id) < TIMER_COUNT);
    case (code)
      REQ_TICK: tick_cnt = tick_cnt + 32'd1;
      REQ_SCAN: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (phase_q[i] == PH_RUNNING) begin
            // plain unsigned compare, a wrapped deadline sits behind the counter and is due at once
            if (due_at[i] <= tick_cnt) begin
              phase_q[i] = PH_TIMEOUT;
              if (n < MAX_RESULTS) begin
                batch[n] = '{kind: KIND_EXPIRY, which: 3'(i), status: PH_TIMEOUT,
                             tag: tag_q[i], tick: tick_cnt, last: 1'b0};
                n++;
              end
            end
          end else if (phase_q[i] == PH_TIMEOUT) begin
            if (!reload_on[i]) begin
              phase_q[i] = PH_STOPPED;
            end else begin
              due_at[i] = tick_cnt + period_q[i];
              phase_q[i] = PH_RUNNING;
            end
          end
        end
      end
      REQ_START: begin
        if (id_ok) begin
          due_at[id]    = tick_cnt + dly;
          period_q[id]  = dly;
          phase_q[id]   = PH_RUNNING;
          reload_on[id] = per;
          tag_q[id]     = tg;
        end
      end
      REQ_STOP: begin
        if (id_ok) phase_q[id] = PH_STOPPED;
      end
      REQ_QUERY: begin
        if (id_ok) begin
          batch[0] = '{kind: KIND_STATE, which: id, status: phase_q[id],
                       tag: tag_q[id], tick: tick_cnt, last: 1'b0};
        end else begin
          batch[0] = '{kind: KIND_STATE, which: id, status: PH_STOPPED,
                       tag: 16'h0000, tick: tick_cnt, last: 1'b0};
        end
        n = 1;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      batch[k].last = (k == n - 1);
      owed_q.push_back(batch[k]);
    end
  endtask

  task automatic report_word(input string why, input timer_word_t want,
                             input timer_word_t got);
    if (mism < 10)
      $display("%0t MISMATCH %s: want k%0d t%0d s%0d tag %h tick %h l%0d",
               $realtime, why, want.kind, want.which, want.status, want.tag,
               want.tick, want.last,
               "  got k%0d t%0d s%0d tag %h tick %h l%0d",
               got.kind, got.which, got.status, got.tag, got.tick, got.last);
    mism++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        phase_q[i]   = PH_STOPPED;
        reload_on[i] = 1'b0;
        due_at[i]    = '0;
        period_q[i]  = '0;
        tag_q[i]     = '0;
      end
      owed_q.delete();
    end else begin
      // take the request first so a same-edge result still finds its word
      if (req_mon.valid && req_mon.ready)
        step_bank(req_mon.req_type, req_mon.timer_id, req_mon.periodic,
                  req_mon.delay_ticks, req_mon.user_tag);
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_w = '{kind: rsp_mon.result_kind, which: rsp_mon.which_timer,
                  status: phase_t'(rsp_mon.timer_status), tag: rsp_mon.expiry_tag,
                  tick: rsp_mon.tick_now, last: rsp_mon.last_of_run};
        if (owed_q.size() == 0) begin
          report_word("word with none owed", '0, got_w);
        end else begin
          want_w = owed_q.pop_front();
          if (got_w.kind !== want_w.kind || got_w.which !== want_w.which ||
              got_w.status !== want_w.status || got_w.tag !== want_w.tag ||
              got_w.tick !== want_w.tick || got_w.last !== want_w.last)
            report_word("field mismatch", want_w, got_w);
          if (want_w.kind == KIND_EXPIRY) n_exp++;
          else n_rep++;
        end
      end
    end
    fail_count    <= mism;
    words_owed    <= owed_q.size();
    expiries_seen <= n_exp;
    replies_seen  <= n_rep;
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the timer bank with a directed opening and a long random request
// stream, toggles output backpressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import swtb_pkg::*;

  localparam int RANDOM_WORDS = 400;            // counted requests, ignored codes excluded
  localparam int CALM_AFTER   = 350;            // from here on, no idling on either side
  localparam int STALL_AT     = 200;            // words sent before the long hold-off
  localparam int HOLD_CYCLES  = 400;            // receiver hold-off length
  localparam int DRAIN_CYCLES = 4 * TIMER_COUNT;
  localparam int WATCHDOG_NS  = 2_000_000;      // watchdog limit; the clock period is 2 ns

  logic clk = 1'b0;
  logic rst_n;

  timer_req_if req_bus ();
  timer_rsp_if rsp_bus ();

  int fail_count;
  int words_owed;
  int expiries_seen;
  int replies_seen;
  int words_sent;
  int scans_sent;
  int ignored_sent;
  bit calm;

  always #1 clk = ~clk;

  software_timer_bank u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_bus),
    .out_rsp(rsp_bus)
  );

  timer_bank_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_mon      (req_bus),
    .rsp_mon      (rsp_bus),
    .fail_count   (fail_count),
    .words_owed   (words_owed),
    .expiries_seen(expiries_seen),
    .replies_seen (replies_seen)
  );

  // Offer one request word and hold it until the block takes it. Called right
  // after a rising edge; leaves on the edge where the word was accepted, so the
  // next word can follow back to back without valid ever dropping.
  task automatic send_req(input logic [2:0] code, input logic [2:0] id, input logic per,
                          input logic [31:0] dly, input logic [15:0] tg);
    // insert a random sender gap now and then, never in the calm tail
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= code;
    req_bus.timer_id    <= id;
    req_bus.periodic    <= per;
    req_bus.delay_ticks <= dly;
    req_bus.user_tag    <= tg;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    words_sent++;
    if (code == REQ_SCAN) scans_sent++;
    if (code > REQ_QUERY) ignored_sent++;
  endtask

  // Result side: random ready bursts, one long hold-off while the sender keeps
  // pushing, and ready held high through the calm tail.
  initial begin : rsp_side
    bit stall_done;
    stall_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm) begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk);
      end else if (!stall_done && words_sent >= STALL_AT) begin
        // hold off long enough to back the block up into its input
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          useful;
    int          pick;
    logic [2:0]  code;
    logic [31:0] dly;
    logic [15:0] tg;

    // hold every input at a known value from time zero
    rst_n               <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_TICK;
    req_bus.timer_id    <= '0;
    req_bus.periodic    <= 1'b0;
    req_bus.delay_ticks <= '0;
    req_bus.user_tag    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed opening ---
    // query straight out of reset: stopped, tag zero
    send_req(REQ_QUERY, 3'd0, 1'b0, 32'd0, 16'h0000);
    // arm every timer with zero delay; odd ones periodic, tag extremes on 0 and 1
    for (int i = 0; i < 8; i++) begin
      tg = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom);
      send_req(REQ_START, 3'(i), 1'(i & 1), 32'd0, tg);
    end
    // all eight expire in one pass: the most words one request can cause
    send_req(REQ_SCAN, 3'd0, 1'b0, 32'd0, 16'h0000);
    send_req(REQ_QUERY, 3'd1, 1'b0, 32'd0, 16'h0000);
    // next pass: one-shots stop, periodics reload from the counter
    send_req(REQ_SCAN, 3'd0, 1'b0, 32'd0, 16'h0000);
    send_req(REQ_QUERY, 3'd0, 1'b0, 32'd0, 16'h0000);
    send_req(REQ_QUERY, 3'd3, 1'b0, 32'd0, 16'h0000);
    // largest delay: deadline sits at the top of the range
    send_req(REQ_START, 3'd2, 1'b1, 32'hFFFF_FFFF, 16'hA5A5);
    send_req(REQ_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_SCAN, 3'd0, 1'b0, 32'd0, 16'h0000);
    send_req(REQ_STOP, 3'd3, 1'b0, 32'd0, 16'h0000);
    // restart a timer that is timed out
    send_req(REQ_START, 3'd5, 1'b0, 32'd1, 16'h8001);
    send_req(REQ_QUERY, 3'd5, 1'b0, 32'd0, 16'h0000);
    // unused request codes carry random fields and must cause nothing
    send_req(3'd5, 3'($urandom), 1'($urandom), $urandom, 16'($urandom));
    send_req(3'd6, 3'($urandom), 1'($urandom), $urandom, 16'($urandom));
    send_req(3'd7, 3'($urandom), 1'($urandom), $urandom, 16'($urandom));
    send_req(REQ_TICK, 3'd0, 1'b0, 32'd0, 16'h0000);
    send_req(REQ_SCAN, 3'd0, 1'b0, 32'd0, 16'h0000);

    // --- random stream ---
    // ticks keep the counter low, so most delays are short enough to expire;
    // a share of huge delays wraps the deadline behind the counter
    useful = 0;
    while (useful < RANDOM_WORDS) begin
      calm = (useful >= CALM_AFTER);
      pick = $urandom_range(0, 99);
      if (pick < 6)       code = 3'($urandom_range(5, 7));
      else if (pick < 34) code = REQ_TICK;
      else if (pick < 54) code = REQ_SCAN;
      else if (pick < 74) code = REQ_START;
      else if (pick < 82) code = REQ_STOP;
      else                code = REQ_QUERY;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: dly = 32'($urandom_range(0, 10));
        6, 7:             dly = $urandom;
        8:                dly = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
        default:          dly = 32'($urandom_range(11, 300));
      endcase
      send_req(code, 3'($urandom), 1'($urandom), dly, 16'($urandom));
      if (code <= REQ_QUERY) useful++;
    end

    // --- drain ---
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d request words: %0d update passes, %0d unused codes",
             words_sent, scans_sent, ignored_sent);
    $display("Checked %0d expiry events and %0d state replies, %0d mismatches",
             expiries_seen, replies_seen, fail_count);
    if (fail_count == 0 && words_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up if the block wedges.
  initial begin : watchdog
    #WATCHDOG_NS;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/swtb_pkg.sv
hdl/swtb_if.sv
hdl/swtb_ctrl.sv
hdl/swtb_dp.sv
hdl/software_timer_bank.sv
tb/sv/timer_bank_checker.sv
tb/sv/testbench.sv
